// ----- hw/rtl/per_beam_running_variance_assert.svh -----
// Assertion macros for the per-beam running variance block.
`ifndef PER_BEAM_RUNNING_VARIANCE_ASSERT_SVH
`define PER_BEAM_RUNNING_VARIANCE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PBRV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PBRV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBRV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PBRV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/pbrv_pkg.sv -----
`default_nettype none
package pbrv_pkg;
    localparam int MAX_BEAMS_DEF  = 1024;
    localparam int COUNT_BITS_DEF = 20;
    localparam logic [10:0] BEAM_COUNT_RST = 11'd720;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        B_IDLE, B_READ, B_UPD, B_DIV, B_SQ, B_OUT, B_CLR
    } t_bstate;
endpackage
`default_nettype wire

// ----- hw/rtl/pbrv_front.sv -----
`default_nettype none
// Front end: classifies items by range check and queues them.
module pbrv_front import pbrv_pkg::*; #(
    parameter int MAX_BEAMS = MAX_BEAMS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [9:0]  i_beam_index,
    input  wire  [15:0] i_range_sample,
    input  wire  [10:0] i_beam_count,
    input  wire         i_block,
    output logic        o_q_valid,
    input  wire         i_q_pop,
    output logic [9:0]  o_q_beam,
    output logic [15:0] o_q_sample,
    output logic        o_q_range_err
);
    localparam int QD = 2;
    logic [9:0]  r_beam [QD];
    logic [15:0] r_smp  [QD];
    logic        r_err  [QD];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, inr;

    assign o_stall = (r_cnt == 2'(QD)) || i_block;
    assign push = i_valid && !o_stall;
    assign inr = ({1'b0, i_beam_index} < i_beam_count) &&
                 ({22'd0, i_beam_index} < 32'(MAX_BEAMS));
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_beam = r_beam[r_rp];
    assign o_q_sample = r_smp[r_rp];
    assign o_q_range_err = r_err[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_beam[r_wp] <= i_beam_index;
            r_smp[r_wp] <= i_range_sample;
            r_err[r_wp] <= !inr;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/pbrv_back.sv -----
`default_nettype none
// Back end: read-modify-write of the beam store, two serial dividers.
module pbrv_back import pbrv_pkg::*; #(
    parameter int MAX_BEAMS  = MAX_BEAMS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_q_valid,
    output logic        o_q_pop,
    input  wire  [9:0]  i_q_beam,
    input  wire  [15:0] i_q_sample,
    input  wire         i_q_range_err,
    output logic        o_clearing,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [9:0]  o_beam_out,
    output logic [23:0] o_mean_value,
    output logic [39:0] o_variance_value,
    output logic [19:0] o_samples_seen,
    output logic [1:0]  o_status_code
);
    localparam int AW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam int SW = 16 + COUNT_BITS;
    localparam int QW = 32 + COUNT_BITS;
    localparam int NW = QW + 8;            // dividend width
    localparam int CW = $clog2(NW + 1);
    localparam int MW = AW < 10 ? AW : 10;

    logic [COUNT_BITS-1:0] m_cnt [MAX_BEAMS];
    logic [SW-1:0]         m_sum [MAX_BEAMS];
    logic [QW-1:0]         m_sq  [MAX_BEAMS];

    t_bstate r_st, n_st;
    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         r_addr;
    logic [9:0]            r_beam;
    logic [15:0]           r_smp;
    logic [COUNT_BITS-1:0] r_rc, r_n;
    logic [SW-1:0]         r_rs;
    logic [QW-1:0]         r_rq;
    logic [1:0]            r_status;
    logic [NW-1:0]         r_qa, r_qb;   // quotient/dividend shift
    logic [COUNT_BITS:0]   r_ra, r_rb;   // partial remainders
    logic [CW-1:0]         r_it;
    logic [47:0]           r_msq;
    logic                  r_wr;
    logic                  r_ov;

    logic [COUNT_BITS:0] ta, tb;
    logic [QW:0] nsq;
    logic        sat;

    assign o_clearing = (r_st == B_CLR);
    assign sat = (r_rc == {COUNT_BITS{1'b1}});
    assign ta = {r_ra[COUNT_BITS-1:0], r_qa[NW-1]};
    assign tb = {r_rb[COUNT_BITS-1:0], r_qb[NW-1]};
    assign nsq = {1'b0, r_rq} + (QW+1)'(32'(r_smp) * 32'(r_smp));

    always_comb begin
        n_st = r_st;
        o_q_pop = 1'b0;
        case (r_st)
            B_CLR:  if (r_clr == AW'(MAX_BEAMS - 1)) n_st = B_IDLE;
            B_IDLE: if (i_q_valid && !r_ov) begin
                o_q_pop = 1'b1;
                n_st = i_q_range_err ? B_OUT : B_READ;
            end
            B_READ: n_st = B_UPD;
            B_UPD:  n_st = (sat || r_rc != '0) ? B_DIV : B_UPD;
            B_DIV:  if (r_it == CW'(NW - 1)) n_st = B_SQ;
            B_SQ:   n_st = B_OUT;
            B_OUT:  n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
        if (r_st == B_UPD && !sat) n_st = B_DIV;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == B_CLR) begin
            m_cnt[r_clr] <= '0;
            m_sum[r_clr] <= '0;
            m_sq[r_clr] <= '0;
        end else if (r_wr) begin
            m_cnt[r_addr] <= r_n;
            m_sum[r_addr] <= r_rs;
            m_sq[r_addr] <= r_rq;
        end
        if (r_st == B_READ) begin
            r_rc <= m_cnt[r_addr];
            r_rs <= m_sum[r_addr];
            r_rq <= m_sq[r_addr];
        end
        r_wr <= 1'b0;
        case (r_st)
            B_IDLE: begin
                r_beam <= i_q_beam;
                r_smp <= i_q_sample;
                r_addr <= AW'(i_q_beam[MW-1:0]);
                r_status <= i_q_range_err ? ST_RANGE : ST_OK;
            end
            B_UPD: begin
                if (sat) begin
                    r_status <= ST_SAT;
                    r_n <= r_rc;
                    r_qa <= NW'({r_rs, 8'd0});
                    r_qb <= NW'({r_rq, 8'd0});
                end else begin
                    r_n <= r_rc + 1'b1;
                    r_rs <= r_rs + SW'(r_smp);
                    r_rq <= nsq[QW-1:0];
                    r_qa <= NW'({r_rs + SW'(r_smp), 8'd0});
                    r_qb <= NW'({nsq[QW-1:0], 8'd0});
                    r_wr <= 1'b1;
                end
                r_ra <= '0;
                r_rb <= '0;
                r_it <= '0;
            end
            B_DIV: begin
                r_it <= r_it + 1'b1;
                if (ta >= {1'b0, r_n}) begin
                    r_ra <= ta - {1'b0, r_n};
                    r_qa <= {r_qa[NW-2:0], 1'b1};
                end else begin
                    r_ra <= ta;
                    r_qa <= {r_qa[NW-2:0], 1'b0};
                end
                if (tb >= {1'b0, r_n}) begin
                    r_rb <= tb - {1'b0, r_n};
                    r_qb <= {r_qb[NW-2:0], 1'b1};
                end else begin
                    r_rb <= tb;
                    r_qb <= {r_qb[NW-2:0], 1'b0};
                end
            end
            B_SQ: r_msq <= 48'(r_qa[23:0]) * 48'(r_qa[23:0]);
            B_OUT: begin
                o_beam_out <= r_beam;
                o_status_code <= r_status;
                if (r_status == ST_RANGE || r_n == '0) begin
                    o_mean_value <= '0;
                    o_variance_value <= '0;
                    o_samples_seen <= '0;
                end else begin
                    o_mean_value <= r_qa[23:0];
                    o_samples_seen <= 20'(r_n);
                    if (64'(r_qb) > 64'(r_msq[47:8]))
                        o_variance_value <= 40'(64'(r_qb) - 64'(r_msq[47:8]));
                    else
                        o_variance_value <= '0;
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_st <= B_CLR;
            r_clr <= '0;
            o_valid <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == B_CLR) r_clr <= r_clr + 1'b1;
            if (r_st == B_OUT) begin
                o_valid <= 1'b1;
                r_ov <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
                r_ov <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/per_beam_running_variance.sv -----
`default_nettype none
// Per-beam running mean and population variance.
// Input channel: i_valid/o_stall with beam index and range sample. Result
// channel: o_valid/i_stall with beam, mean and variance (8 fraction bits),
// sample count and status. One result per item.
// Range errors go straight to the output; good items pass through read,
// update, the two bit-serial dividers running one quotient bit per cycle
// over sum and sum of squares, squaring of the mean and output.
// One item is worked at a time; a two-entry queue takes items meanwhile.
// After reset a clearing pass zeroes every entry of the beam store; no item
// is accepted during it. beam_count resets to 720 and is written by
// i_cfg_we/i_cfg_data.
// A stalled result holds in the output register; the back end waits for
// it to leave before starting the next item while the queue keeps filling.
module per_beam_running_variance import pbrv_pkg::*; #(
    parameter int MAX_BEAMS  = MAX_BEAMS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [9:0]  i_beam_index,
    input  wire  [15:0] i_range_sample,
    input  wire         i_cfg_we,
    input  wire  [10:0] i_cfg_data,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [9:0]  o_beam_out,
    output logic [23:0] o_mean_value,
    output logic [39:0] o_variance_value,
    output logic [19:0] o_samples_seen,
    output logic [1:0]  o_status_code
);
`include "per_beam_running_variance_assert.svh"
    logic [10:0] r_beam_count;
    logic q_valid, q_pop, q_err, clearing;
    logic [9:0] q_beam;
    logic [15:0] q_smp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_beam_count <= BEAM_COUNT_RST;
        else if (i_cfg_we) r_beam_count <= i_cfg_data;
    end

    pbrv_front #(.MAX_BEAMS(MAX_BEAMS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_beam_index, .i_range_sample,
        .i_beam_count(r_beam_count), .i_block(clearing),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_beam(q_beam),
        .o_q_sample(q_smp), .o_q_range_err(q_err)
    );

    pbrv_back #(.MAX_BEAMS(MAX_BEAMS), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_beam(q_beam), .i_q_sample(q_smp), .i_q_range_err(q_err),
        .o_clearing(clearing), .o_valid, .i_stall, .o_beam_out, .o_mean_value,
        .o_variance_value, .o_samples_seen, .o_status_code
    );

    `PBRV_ASSERT_IMP(a_pop_has_item, i_clk, i_rst_n, q_pop, q_valid, "pop of empty queue")
    `PBRV_ASSERT_IMP(a_no_accept_clr, i_clk, i_rst_n, clearing, o_stall, "accept during clear")
    `PBRV_ASSERT_IMP(a_status_ok, i_clk, i_rst_n, o_valid, o_status_code != 2'd3, "bad status")
    `PBRV_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_mean_value), "result dropped")
endmodule
`default_nettype wire
